// ===== rtl/core/clog_pkg.sv =====
// shared types and constants for the complex natural log core
// no dependencies; imported by the cells and the top level
package clog_pkg;

    localparam int LOG_STEPS  = 16;
    localparam int LOG_LAT    = 21;
    localparam int ATAN_LEN   = 24;
    localparam int XY_W       = 32;
    localparam int Z_W        = 30;

    localparam logic [31:0] LN2_HALF_Q32 = 32'd1488522236;
    localparam logic [26:0] HALF_PI_Q26  = 27'd105414357;
    localparam logic [15:0] PI_Q13       = 16'd25736;
    localparam logic [15:0] LOG_ZERO     = 16'h8000;

    localparam logic [25:0] ATAN_TAB [ATAN_LEN] = '{
        26'd52707179, 26'd31114864, 26'd16440240, 26'd8345322,
        26'd4188855,  26'd2096470,  26'd1048491,  26'd524277,
        26'd262143,   26'd131072,   26'd65536,    26'd32768,
        26'd16384,    26'd8192,     26'd4096,     26'd2048,
        26'd1024,     26'd512,      26'd256,      26'd128,
        26'd64,       26'd32,       26'd16,       26'd8
    };

    typedef struct packed {
        logic [XY_W-1:0] x;
        logic [XY_W-1:0] y;
        logic [Z_W-1:0]  z;
    } cr_t;

    typedef struct packed {
        logic [31:0]          m;
        logic [LOG_STEPS-1:0] frac;
        logic [4:0]           p;
    } lg_t;

endpackage

// ===== rtl/core/complex_natural_log_core.sv =====
// top level of the complex natural log core: input stage, log and cordic
// cell chains, alignment delays and output skid; depends on clog_pkg,
// clog_sq_cell and clog_cordic_cell
//
//  channel  dir  tdata                              tuser       tlast
//  s_       in   real_part, imag_part               -           last_in
//  m_       out  log_magnitude, phase               zero_input  last_out
//
// one request per cycle sustained while the skid stage is empty
// the log chain is of fixed length, the cordic chain sets the rest
// rst_n clears the control line, valid and skid state only
// the whole chain freezes while the skid stage holds a result
module complex_natural_log_core
    import clog_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // real_part, imag_part
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // log_magnitude, phase
    output logic [0:0]  m_tuser,   // zero_input
    output logic        m_tlast
);

    localparam int NSTG = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN :
                          ((CORDIC_STAGES < 0) ? 0 : CORDIC_STAGES);
    localparam int FIN  = (LOG_LAT > NSTG + 1) ? LOG_LAT : NSTG + 1;
    localparam int LPAD = FIN - LOG_LAT;
    localparam int PPAD = FIN - NSTG - 1;

    logic en;

    // control line
    logic [FIN:0] vld_reg;
    logic [FIN:0] last_reg;
    logic [FIN:0] zero_reg;

    // input stage
    logic signed [15:0] re_s;
    logic signed [15:0] im_s;
    logic signed [16:0] re17;
    logic signed [16:0] im17;
    logic signed [16:0] x17;
    logic signed [16:0] y17;
    logic signed [Z_W-1:0] z0;
    logic signed [31:0] re2;
    logic signed [31:0] im2;
    logic [31:0] re2_reg;
    logic [31:0] im2_reg;
    cr_t         cr0_next;
    cr_t         cr0_reg;

    // log path
    logic [31:0] sum_reg;
    logic [31:0] sum2_reg;
    logic [4:0]  p_next;
    logic [4:0]  p_reg;
    lg_t         lg0_reg;
    lg_t         lg_st [0:LOG_STEPS];
    logic signed [6:0]  pm;
    logic signed [21:0] lval;
    logic signed [53:0] prod_next;
    logic signed [53:0] prod_reg;
    logic [52:0] mag;
    logic [53:0] rsum;
    logic signed [17:0] rval;
    logic [15:0] logv_next;
    logic [15:0] logv_reg;
    logic [15:0] lpad [0:LPAD];

    // phase path
    cr_t         cr_st [0:NSTG];
    logic signed [Z_W:0] zr;
    logic signed [17:0]  zq;
    logic [15:0] ph_next;
    logic [15:0] ph_reg;
    logic [15:0] ppad [0:PPAD];

    // output skid
    logic        push;
    logic        take;
    logic [33:0] res_next;
    logic [33:0] out_reg;
    logic [33:0] skid_reg;
    logic        out_valid_reg;
    logic        skid_valid_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // input stage: squares and quadrant pre-rotation
    always_comb
    begin
        re_s = $signed(s_tdata[15:0]);
        im_s = $signed(s_tdata[31:16]);
        re2  = re_s * re_s;
        im2  = im_s * im_s;
        re17 = 17'(re_s);
        im17 = 17'(im_s);
        if (re17 < 0)
        begin
            if (im17 >= 0)
            begin
                x17 = im17;
                y17 = -re17;
                z0  = $signed({{(Z_W-27){1'b0}}, HALF_PI_Q26});
            end
            else
            begin
                x17 = -im17;
                y17 = re17;
                z0  = -$signed({{(Z_W-27){1'b0}}, HALF_PI_Q26});
            end
        end
        else
        begin
            x17 = re17;
            y17 = im17;
            z0  = '0;
        end
        cr0_next.x = {x17[16], x17, 14'b0};
        cr0_next.y = {y17[16], y17, 14'b0};
        cr0_next.z = z0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            last_reg <= '0;
            zero_reg <= '0;
        end
        else if (en)
        begin
            vld_reg  <= {vld_reg[FIN-1:0], s_tvalid};
            last_reg <= {last_reg[FIN-1:0], s_tlast};
            zero_reg <= {zero_reg[FIN-1:0], (s_tdata == 32'd0)};
        end
    end

    // leading one search
    always_comb
    begin
        p_next = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (sum_reg[i])
            begin
                p_next = 5'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            re2_reg      <= re2;
            im2_reg      <= im2;
            cr0_reg      <= cr0_next;
            sum_reg      <= re2_reg + im2_reg;
            sum2_reg     <= sum_reg;
            p_reg        <= p_next;
            lg0_reg.m    <= sum2_reg << (5'd31 - p_reg);
            lg0_reg.frac <= '0;
            lg0_reg.p    <= p_reg;
            prod_reg     <= prod_next;
            logv_reg     <= logv_next;
            ph_reg       <= ph_next;
        end
    end

    assign lg_st[0] = lg0_reg;

    generate
        for (genvar k = 0; k < LOG_STEPS; k++)
        begin : g_sq
            clog_sq_cell u_sq (
                .clk  (clk),
                .en   (en),
                .din  (lg_st[k]),
                .dout (lg_st[k+1])
            );
        end
    endgenerate

    // scale by ln(2)/2, round ties away from zero, saturate
    always_comb
    begin
        pm        = $signed({2'b00, lg_st[LOG_STEPS].p}) - 7'sd30;
        lval      = $signed({pm[5:0], lg_st[LOG_STEPS].frac});
        prod_next = $signed({{32{lval[21]}}, lval}) * $signed({22'b0, LN2_HALF_Q32});
        mag       = prod_reg[53] ? 53'(-prod_reg) : prod_reg[52:0];
        rsum      = {1'b0, mag} + (54'd1 << 36);
        rval      = prod_reg[53] ? -$signed({1'b0, rsum[53:37]})
                                 : $signed({1'b0, rsum[53:37]});
        if (rval > 18'sd32767)
        begin
            logv_next = 16'h7fff;
        end
        else if (rval < -18'sd32768)
        begin
            logv_next = 16'h8000;
        end
        else
        begin
            logv_next = rval[15:0];
        end
    end

    assign cr_st[0] = cr0_reg;

    generate
        for (genvar k = 0; k < NSTG; k++)
        begin : g_cr
            clog_cordic_cell #(
                .STAGE (k)
            ) u_cr (
                .clk  (clk),
                .en   (en),
                .din  (cr_st[k]),
                .dout (cr_st[k+1])
            );
        end
    endgenerate

    // phase rounding to q3.13 and clamp to +-pi
    always_comb
    begin
        zr = $signed({cr_st[NSTG].z[Z_W-1], cr_st[NSTG].z}) + (Z_W+1)'(4096);
        zq = 18'(zr >>> 13);
        if (zq > $signed({2'b00, PI_Q13}))
        begin
            ph_next = PI_Q13;
        end
        else if (zq < -$signed({2'b00, PI_Q13}))
        begin
            ph_next = 16'(-$signed({2'b00, PI_Q13}));
        end
        else
        begin
            ph_next = zq[15:0];
        end
    end

    // alignment delays
    assign lpad[0] = logv_reg;
    assign ppad[0] = ph_reg;

    generate
        for (genvar j = 1; j <= LPAD; j++)
        begin : g_lpad
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    lpad[j] <= lpad[j-1];
                end
            end
        end
        for (genvar j = 1; j <= PPAD; j++)
        begin : g_ppad
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    ppad[j] <= ppad[j-1];
                end
            end
        end
    endgenerate

    // output register and skid stage
    assign push = en && vld_reg[FIN];
    assign take = out_valid_reg && m_tready;

    always_comb
    begin
        if (zero_reg[FIN])
        begin
            res_next = {last_reg[FIN], 1'b1, 16'd0, LOG_ZERO};
        end
        else
        begin
            res_next = {last_reg[FIN], 1'b0, ppad[PPAD], lpad[LPAD]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (out_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (push)
            begin
                out_reg <= res_next;
            end
        end
        else if (push)
        begin
            if (out_valid_reg)
            begin
                skid_reg <= res_next;
            end
            else
            begin
                out_reg <= res_next;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg[31:0];
    assign m_tuser  = out_reg[32];
    assign m_tlast  = out_reg[33];

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while the output register is empty");

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[15:0] == LOG_ZERO && m_tdata[31:16] == 16'd0))
        else $error("zero sample without saturated log and zero phase");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[31:16]) <= $signed(PI_Q13)
                      && $signed(m_tdata[31:16]) >= -$signed(PI_Q13)))
        else $error("phase outside +-pi");

    a_chain_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("cell chain moved while stalled");

endmodule

// ===== rtl/core/clog_sq_cell.sv =====
// one log2 fraction cell: squares the mantissa and yields one fraction bit
// depends on clog_pkg
module clog_sq_cell
    import clog_pkg::*;
(
    input  logic clk,
    input  logic en,
    input  lg_t  din,
    output lg_t  dout
);

    logic [63:0] sq;
    logic [32:0] t;
    lg_t         cell_next;
    lg_t         cell_reg;

    always_comb
    begin
        sq = 64'(din.m) * 64'(din.m);
        t  = sq[63:31];
        cell_next.p = din.p;
        if (t[32])
        begin
            cell_next.m    = t[32:1];
            cell_next.frac = {din.frac[LOG_STEPS-2:0], 1'b1};
        end
        else
        begin
            cell_next.m    = t[31:0];
            cell_next.frac = {din.frac[LOG_STEPS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

// ===== rtl/core/clog_cordic_cell.sv =====
// one cordic vectoring cell with a fixed shift and angle step
// depends on clog_pkg
module clog_cordic_cell
    import clog_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  logic clk,
    input  logic en,
    input  cr_t  din,
    output cr_t  dout
);

    logic signed [XY_W-1:0] x_s;
    logic signed [XY_W-1:0] y_s;
    logic signed [Z_W-1:0]  z_s;
    logic signed [XY_W-1:0] x_sh;
    logic signed [XY_W-1:0] y_sh;
    logic signed [Z_W-1:0]  ang;
    cr_t                    cell_next;
    cr_t                    cell_reg;

    always_comb
    begin
        x_s  = $signed(din.x);
        y_s  = $signed(din.y);
        z_s  = $signed(din.z);
        x_sh = x_s >>> STAGE;
        y_sh = y_s >>> STAGE;
        ang  = $signed({{(Z_W-26){1'b0}}, ATAN_TAB[STAGE]});
        if (!din.y[XY_W-1])
        begin
            cell_next.x = x_s + y_sh;
            cell_next.y = y_s - x_sh;
            cell_next.z = z_s + ang;
        end
        else
        begin
            cell_next.x = x_s - y_sh;
            cell_next.y = y_s + x_sh;
            cell_next.z = z_s - ang;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

// ===== tb/complex_natural_log_core_tb.sv =====
// testbench for complex_natural_log_core: drives complex samples over the stream
// input, predicts the log magnitude and phase of each request, checks every result
// depends on clog_pkg and complex_natural_log_core
`timescale 1ns / 1ps

module complex_natural_log_core_tb;
    import clog_pkg::*;

    localparam int CORDIC_STAGES = 16;
    localparam int RANDOM_ITEMS  = 1200;
    localparam int DRAIN_CYCLES  = 60;
    localparam longint CYCLE_LIMIT = 1000000;

    typedef struct {
        logic signed [15:0] log_mag;
        logic signed [15:0] phase;
        logic               zero;
        logic               last;
    } clog_result_t;

    class clog_scoreboard;
        clog_result_t expected_q[$];
        int mismatches;
        int requests;
        int results;
        int zero_requests;
        int last_requests;

        function new();
            mismatches    = 0;
            requests      = 0;
            results       = 0;
            zero_requests = 0;
            last_requests = 0;
        endfunction

        function automatic logic signed [15:0] ln_magnitude_q11(longint unsigned sq);
            int p;
            longint unsigned m;
            longint frac;
            longint l;
            longint prod;
            longint mag;
            p    = 31;
            frac = 0;
            while (p > 0 && sq[p] == 1'b0)
                p--;
            m = sq << (31 - p);
            for (int k = 0; k < LOG_STEPS; k++)
            begin
                m    = (m * m) >> 31;
                frac = frac << 1;
                if (m >= 64'h1_0000_0000)
                begin
                    frac = frac | 1;
                    m    = m >> 1;
                end
            end
            l    = longint'(p - 30) * 65536 + frac;
            prod = l * longint'(LN2_HALF_Q32);
            mag  = (prod < 0) ? -prod : prod;
            mag  = (mag + (longint'(1) << 36)) >>> 37;
            if (prod < 0)
                mag = -mag;
            if (mag > 32767)
                mag = 32767;
            if (mag < -32768)
                mag = -32768;
            return mag[15:0];
        endfunction

        function automatic logic signed [15:0] atan2_q13(longint re, longint im);
            longint x;
            longint y;
            longint z;
            longint nx;
            longint ny;
            longint pi_q13;
            int     n;
            n = CORDIC_STAGES;
            if (n > ATAN_LEN)
                n = ATAN_LEN;
            if (n < 0)
                n = 0;
            // quadrant pre-rotation by a quarter turn when the real part is negative
            if (re < 0)
            begin
                if (im >= 0)
                begin
                    x = im;
                    y = -re;
                    z = longint'(HALF_PI_Q26);
                end
                else
                begin
                    x = -im;
                    y = re;
                    z = -longint'(HALF_PI_Q26);
                end
            end
            else
            begin
                x = re;
                y = im;
                z = 0;
            end
            x = x * 16384;
            y = y * 16384;
            for (int i = 0; i < n; i++)
            begin
                if (y >= 0)
                begin
                    nx = x + (y >>> i);
                    ny = y - (x >>> i);
                    z  = z + longint'(ATAN_TAB[i]);
                end
                else
                begin
                    nx = x - (y >>> i);
                    ny = y + (x >>> i);
                    z  = z - longint'(ATAN_TAB[i]);
                end
                x = nx;
                y = ny;
            end
            pi_q13 = longint'(PI_Q13);
            z = (z + 4096) >>> 13;
            if (z > pi_q13)
                z = pi_q13;
            if (z < -pi_q13)
                z = -pi_q13;
            return z[15:0];
        endfunction

        function void note_request(logic signed [15:0] re, logic signed [15:0] im,
                                   logic last);
            clog_result_t    r;
            longint          re_l;
            longint          im_l;
            longint unsigned sq;
            re_l = re;
            im_l = im;
            sq   = longint'(re_l * re_l + im_l * im_l);
            if (sq == 0)
            begin
                r.log_mag = LOG_ZERO;
                r.phase   = '0;
                r.zero    = 1'b1;
                zero_requests++;
            end
            else
            begin
                r.log_mag = ln_magnitude_q11(sq);
                r.phase   = atan2_q13(re_l, im_l);
                r.zero    = 1'b0;
            end
            r.last = last;
            if (last)
                last_requests++;
            requests++;
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [31:0] data, logic zero, logic last);
            clog_result_t e;
            results++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: log %0d phase %0d zero %0b last %0b",
                             $signed(data[15:0]), $signed(data[31:16]), zero, last);
                return;
            end
            e = expected_q.pop_front();
            if (data[15:0] !== e.log_mag || data[31:16] !== e.phase ||
                zero !== e.zero || last !== e.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch at result %0d: expected log %0d phase %0d",
                              " zero %0b last %0b, got log %0d phase %0d",
                              " zero %0b last %0b"},
                             results, e.log_mag, e.phase, e.zero, e.last,
                             $signed(data[15:0]), $signed(data[31:16]), zero, last);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void close_out();
            if (expected_q.size() != 0)
            begin
                mismatches += expected_q.size();
                $display("%0d expected results never arrived", expected_q.size());
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // real_part, imag_part
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // log_magnitude, phase
    logic [0:0]  m_tuser;   // zero_input
    logic        m_tlast;

    clog_scoreboard sb = new();
    longint cycles = 0;
    bit     src_quiet = 1'b0;

    complex_natural_log_core #(.CORDIC_STAGES(CORDIC_STAGES)) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
        clk = 1'b0;

    always #1 clk = ~clk;

    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_sample(logic signed [15:0] re, logic signed [15:0] im, logic last);
        int gap;
        gap = pick_gap(src_quiet);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {im, re};
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    function automatic logic signed [15:0] random_part();
        logic signed [15:0] v;
        case ($urandom_range(0, 5))
            0, 1, 2: v = 16'($urandom());
            3:
            begin
                v = 16'($urandom_range(0, 15));
                if ($urandom_range(0, 1))
                    v = -v;
            end
            4:
            begin
                case ($urandom_range(0, 4))
                    0: v = 16'sh8000;
                    1: v = 16'sh7fff;
                    2: v = -16'sd1;
                    3: v = 16'sd1;
                    default: v = 16'sd0;
                endcase
            end
            default: v = 16'sd0;
        endcase
        return v;
    endfunction

    // ready side: random stalls with quiet stretches
    initial
    begin
        int stall_left;
        int phase_cnt;
        bit sink_quiet;
        stall_left = 0;
        phase_cnt  = 0;
        sink_quiet = 1'b0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            phase_cnt++;
            if (phase_cnt >= 300)
            begin
                phase_cnt  = 0;
                sink_quiet = ($urandom_range(0, 3) == 0);
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready   <= 1'b1;
                stall_left = pick_gap(sink_quiet);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("complex_natural_log_core verification failed");
            $finish;
        end
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tdata[15:0], s_tdata[31:16], s_tlast);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser[0], m_tlast);
        end
    end

    initial
    begin
        logic signed [15:0] re;
        logic signed [15:0] im;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        rst_n    = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero sample, axes, negative real axis, extremes and diagonals
        send_sample(16'sd0, 16'sd0, 1'b0);
        send_sample(16'sh7fff, 16'sd0, 1'b0);
        send_sample(16'sh8000, 16'sd0, 1'b1);
        send_sample(-16'sd1, 16'sd0, 1'b0);
        send_sample(16'sd1, 16'sd0, 1'b0);
        send_sample(16'sd0, 16'sh7fff, 1'b0);
        send_sample(16'sd0, 16'sh8000, 1'b0);
        send_sample(16'sd0, 16'sd1, 1'b0);
        send_sample(16'sd0, -16'sd1, 1'b1);
        send_sample(16'sh8000, 16'sh8000, 1'b0);
        send_sample(16'sh7fff, 16'sh7fff, 1'b0);
        send_sample(16'sh7fff, 16'sh8000, 1'b0);
        send_sample(16'sh8000, 16'sh7fff, 1'b0);
        send_sample(16'sh8000, 16'sd1, 1'b0);
        send_sample(16'sh8000, -16'sd1, 1'b0);
        send_sample(-16'sd1, -16'sd1, 1'b0);
        send_sample(-16'sd1, 16'sd1, 1'b0);
        send_sample(16'sd1, 16'sd1, 1'b0);
        send_sample(16'sd1, -16'sd1, 1'b1);
        send_sample(16'sd0, 16'sd0, 1'b1);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
                src_quiet = ($urandom_range(0, 3) == 0);
            re = random_part();
            im = random_part();
            if ($urandom_range(0, 15) == 0)
                im = $urandom_range(0, 1) ? re : -re;
            send_sample(re, im, $urandom_range(0, 7) == 0);
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.close_out();

        $display({"run covered %0d samples (%0d zero, %0d with last marker),",
                  " %0d results checked"},
                 sb.requests, sb.zero_requests, sb.last_requests, sb.results);
        $display("mismatches counted: %0d", sb.mismatches);
        if (sb.mismatches == 0)
            $display("complex_natural_log_core verification clean");
        else
            $display("complex_natural_log_core verification failed");
        $finish;
    end

endmodule
